FILE: hw/rtl/brbf_pkg.sv
// Shared types, codes and defaults for the block ring byte FIFO.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package brbf_pkg;

    // Default sizes, handed to the top level parameters
    localparam int DEF_MAX_SLOTS   = 16;
    localparam int DEF_BLOCK_BYTES = 64;

    // Field widths fixed by the item formats
    localparam int DATA_W   = 8;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 4;
    localparam int FILL_W   = 7;
    localparam int LOG2_W   = 3;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_LOG2 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD   = 2'd1;

    // Reset values of the configuration registers
    localparam logic [LOG2_W-1:0] RST_SLOT_LOG2 = 3'd4;
    localparam logic [FILL_W-1:0] RST_PAYLOAD   = 7'd64;

    // Command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic              command;
        logic [DATA_W-1:0] write_data;
        logic              write_last;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   read_data;
        logic [COUNT_W-1:0]  blocks_committed;
    } t_out_item;

    // Configuration as seen by the executor
    typedef struct packed {
        logic [LOG2_W-1:0] slot_log2;
        logic [FILL_W-1:0] payload;
        logic              clear;
    } t_cfg;

endpackage

FILE: hw/rtl/brbf_front.sv
// Front end: accepts items and holds them in a two-entry queue.
// Depends on brbf_pkg for the item type.
`timescale 1ns / 1ps

module brbf_front import brbf_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_item,
    output logic     o_q_valid,
    input  logic     i_q_ready,
    output t_in_item o_q_item
);

    t_in_item   r_q [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_in_ready = (r_cnt != 2'd2);
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_item   = r_q[r_rd];
    assign push       = i_in_valid && o_in_ready;
    assign pop        = o_q_valid && i_q_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    // Payload: no reset
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= i_in_item;
        end
    end

endmodule

FILE: hw/rtl/brbf_back.sv
// Back end: ring pointers, byte store, block length store and result register.
// Depends on brbf_pkg for item, config and status types.
`timescale 1ns / 1ps

module brbf_back import brbf_pkg::*; #(
    parameter int MAX_SLOTS   = DEF_MAX_SLOTS,
    parameter int BLOCK_BYTES = DEF_BLOCK_BYTES
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_q_valid,
    output logic      o_q_ready,
    input  t_in_item  i_q_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam int IW      = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int OFF_LIM = (BLOCK_BYTES < 128) ? BLOCK_BYTES : 128;
    localparam int OFF_W   = $clog2(OFF_LIM);
    localparam int AW      = IW + OFF_W;
    localparam int DEPTH   = MAX_SLOTS << OFF_W;
    localparam int SN_W    = (IW + 1 > 8) ? IW + 1 : 8;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic [IW-1:0]     r_head, n_head, r_tail, n_tail;
    logic [FILL_W-1:0] r_off, n_off, r_fill, n_fill;
    logic              r_drop, n_drop;
    logic [DATA_W-1:0] r_mem_q;
    logic [FILL_W-1:0] r_used_q;
    logic              r_out_valid;
    t_out_item         r_out, n_out;
    logic              out_load;

    logic [DATA_W-1:0] mem_bytes [DEPTH];
    logic [FILL_W-1:0] mem_used  [MAX_SLOTS];

    logic [LOG2_W-1:0] log2_eff;
    logic [SN_W-1:0]   slot_pow, slots;
    logic [FILL_W-1:0] payload;
    logic [SN_W-1:0]   tail_inc, head_inc, diff;
    logic [IW-1:0]     tail_next, head_next;
    logic [FILL_W-1:0] fill_inc, off_inc;
    logic              out_free, start, is_write, is_read;
    logic              full, empty, commit, byte_we, used_we, rd_en;
    logic [AW-1:0]     wr_addr, rd_addr;

    // Slots in use: at least two, at most MAX_SLOTS
    always_comb begin
        log2_eff = (i_cfg.slot_log2 == '0) ? LOG2_W'(1) : i_cfg.slot_log2;
        slot_pow = SN_W'(1) << log2_eff;
        slots    = (slot_pow > SN_W'(MAX_SLOTS)) ? SN_W'(MAX_SLOTS) : slot_pow;
        if (i_cfg.payload == '0) begin
            payload = FILL_W'(1);
        end else if (32'(i_cfg.payload) > BLOCK_BYTES) begin
            payload = FILL_W'(BLOCK_BYTES);
        end else begin
            payload = i_cfg.payload;
        end
    end

    // Indices wrap by compare against the slot count
    assign tail_inc  = SN_W'(r_tail) + SN_W'(1);
    assign head_inc  = SN_W'(r_head) + SN_W'(1);
    assign tail_next = (tail_inc >= slots) ? '0 : tail_inc[IW-1:0];
    assign head_next = (head_inc >= slots) ? '0 : head_inc[IW-1:0];

    assign out_free  = !r_out_valid || i_out_ready;
    assign o_q_ready = (r_state == S_IDLE) && out_free;
    assign start     = o_q_ready && i_q_valid;
    assign is_write  = start && (i_q_item.command == CMD_WRITE);
    assign is_read   = start && (i_q_item.command == CMD_READ);

    assign full     = r_drop || (tail_next == r_head);
    assign empty    = (r_head == r_tail);
    assign fill_inc = r_fill + FILL_W'(1);
    assign off_inc  = r_off + FILL_W'(1);
    assign commit   = (fill_inc >= payload) || i_q_item.write_last;
    assign byte_we  = is_write && !full;
    assign used_we  = byte_we && commit;
    assign rd_en    = is_read && !empty;
    assign wr_addr  = {r_tail, r_fill[OFF_W-1:0]};
    assign rd_addr  = {r_head, r_off[OFF_W-1:0]};

    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_tail   = r_tail;
        n_off    = r_off;
        n_fill   = r_fill;
        n_drop   = r_drop;
        out_load = 1'b0;
        n_out.status    = ST_OK;
        n_out.read_data = '0;
        unique case (r_state)
            S_IDLE: begin
                if (is_write) begin
                    out_load = 1'b1;
                    if (full) begin
                        n_out.status = ST_FULL;
                        n_drop       = !i_q_item.write_last;
                    end else if (commit) begin
                        n_fill = '0;
                        n_tail = tail_next;
                    end else begin
                        n_fill = fill_inc;
                    end
                end else if (is_read) begin
                    if (empty) begin
                        out_load     = 1'b1;
                        n_out.status = ST_EMPTY;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                out_load        = 1'b1;
                n_out.read_data = r_mem_q;
                if (off_inc >= r_used_q) begin
                    n_off  = '0;
                    n_head = head_next;
                end else begin
                    n_off = off_inc;
                end
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        diff = (n_tail >= n_head) ? SN_W'(n_tail) - SN_W'(n_head)
                                  : SN_W'(n_tail) + slots - SN_W'(n_head);
        n_out.blocks_committed = diff[COUNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_off       <= '0;
            r_fill      <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.clear) begin
                r_head <= '0;
                r_tail <= '0;
                r_off  <= '0;
                r_fill <= '0;
                r_drop <= 1'b0;
            end else begin
                r_head <= n_head;
                r_tail <= n_tail;
                r_off  <= n_off;
                r_fill <= n_fill;
                r_drop <= n_drop;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (byte_we) begin
            mem_bytes[wr_addr] <= i_q_item.write_data;
        end
        if (rd_en) begin
            r_mem_q <= mem_bytes[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (used_we) begin
            mem_used[r_tail] <= fill_inc;
        end
        if (rd_en) begin
            r_used_q <= mem_used[r_head];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

FILE: hw/rtl/block_ring_byte_fifo.sv
// Top level of the block ring byte FIFO: configuration registers, front queue, back end.
// Depends on brbf_pkg, brbf_front and brbf_back.
//
//   channel  | valid      | ready       | payload
//   ---------+------------+-------------+---------------------------
//   in       | i_in_valid | o_in_ready  | i_in_item  (t_in_item)
//   out      | o_out_valid| i_out_ready | o_out_item (t_out_item)
//   cfg      | i_cfg_valid| o_cfg_ready | i_cfg_index, i_cfg_data
//
// A write item is handled in S_IDLE alone; a read item of a non-empty ring also
// passes through S_READ, because the byte store and the block length store have a
// registered read port. An empty read or a rejected write is handled in S_IDLE alone.
// The two-entry front queue accepts until full while the back end works or result waits.
// Reset (synchronous, active low) clears pointers, fill count and drop flag; the stores
// need no clearing pass. A slot count write empties the ring in the same cycle.
`timescale 1ns / 1ps

module block_ring_byte_fifo import brbf_pkg::*; #(
    parameter int MAX_SLOTS   = DEF_MAX_SLOTS,
    parameter int BLOCK_BYTES = DEF_BLOCK_BYTES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [LOG2_W-1:0] r_slot_log2;
    logic [FILL_W-1:0] r_payload;
    logic              slot_wr;
    t_cfg              cfg;
    logic              q_valid, q_ready;
    t_in_item          q_item;

    // Configuration is always taken; the user lets writes arrive only while the block is idle (unenforced)
    assign o_cfg_ready = 1'b1;
    assign slot_wr     = i_cfg_valid && (i_cfg_index == CFG_SLOT_LOG2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_log2 <= RST_SLOT_LOG2;
            r_payload   <= RST_PAYLOAD;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SLOT_LOG2: r_slot_log2 <= i_cfg_data[LOG2_W-1:0];
                CFG_PAYLOAD:   r_payload   <= i_cfg_data[FILL_W-1:0];
                default:       ;  // drop writes to unknown indices
            endcase
        end
    end

    // Empty the ring along with a slot count write
    assign cfg.slot_log2 = r_slot_log2;
    assign cfg.payload   = r_payload;
    assign cfg.clear     = slot_wr;

    brbf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_q_valid  (q_valid),
        .i_q_ready  (q_ready),
        .o_q_item   (q_item)
    );

    brbf_back #(
        .MAX_SLOTS   (MAX_SLOTS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_q_valid   (q_valid),
        .o_q_ready   (q_ready),
        .i_q_item    (q_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

FILE: hw/rtl/brbf_checker.sv
// Port-level checks for the block ring byte FIFO, bound to the top level.
// Depends on brbf_pkg and block_ring_byte_fifo.
`timescale 1ns / 1ps

module brbf_checker import brbf_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_item
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before it was taken");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_item))
        else $error("result changed while stalled");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status == ST_EMPTY) |->
        (o_out_item.read_data == '0) && (o_out_item.blocks_committed == '0))
        else $error("empty read reports data or committed blocks");

    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status == ST_FULL) |-> (o_out_item.read_data == '0))
        else $error("rejected write reports read data");

endmodule

bind block_ring_byte_fifo brbf_checker u_brbf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
